FILE: rtl/core/ptstu_pkg.sv
// ----------------------------------------------------------------------------
// ptstu_pkg: shared types and constants
// Command codes, event kinds and the queue word passed from front to back.
// ----------------------------------------------------------------------------
package ptstu_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int IDX_W     = 4;

    typedef enum logic [3:0] {
        CMD_TICK       = 4'd0,
        CMD_REG_TASK   = 4'd1,
        CMD_STOP_TASK  = 4'd2,
        CMD_START_TASK = 4'd3,
        CMD_SET_PERIOD = 4'd4,
        CMD_REG_TIMER  = 4'd5,
        CMD_RELOAD     = 4'd6,
        CMD_START_TMR  = 4'd7,
        CMD_STOP_TMR   = 4'd8,
        CMD_READ_TMR   = 4'd9
    } cmd_t;

    localparam logic [1:0] EV_REPLY = 2'd0;
    localparam logic [1:0] EV_EXPIRE = 2'd1;
    localparam logic [1:0] EV_DUE = 2'd2;
    localparam logic [1:0] EV_DONE = 2'd3;

    localparam logic [1:0] CFG_TICK_MS = 2'd0;
    localparam logic [1:0] CFG_TASKS = 2'd1;
    localparam logic [1:0] CFG_TIMERS = 2'd2;

    // Classified command handed from the front end to the back end.
    typedef struct packed {
        logic [3:0]  cmd;
        logic [7:0]  id;
        logic [31:0] val;
    } qword_t;

endpackage

FILE: rtl/core/ptstu_front.sv
// ----------------------------------------------------------------------------
// ptstu_front: input stage and command queue
// Registers incoming words into a four-entry queue drained by the back end.
// ----------------------------------------------------------------------------
module ptstu_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ptstu_pkg::qword_t    in_word,
    output logic                 q_valid,
    input  logic                 q_pop,
    output ptstu_pkg::qword_t    q_word
);

    ptstu_pkg::qword_t mem_reg [4];
    logic [1:0] wr_reg, rd_reg;
    logic [2:0] cnt_reg;
    logic push;

    assign in_ready = (cnt_reg != 3'd4);
    assign push = in_valid && in_ready;
    assign q_valid = (cnt_reg != 3'd0);
    assign q_word = mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= in_word;
        end
        if (!aresetn) begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= wr_reg + 2'd1;
            if (q_pop) rd_reg <= rd_reg + 2'd1;
            cnt_reg <= cnt_reg + {2'd0, push} - {2'd0, q_pop};
        end
    end

endmodule

FILE: rtl/core/ptstu_divchk.sv
// ----------------------------------------------------------------------------
// ptstu_divchk: serial divisibility check
// Restoring division of a 32-bit value by tick_ms, one bit per cycle.
// ----------------------------------------------------------------------------
module ptstu_divchk (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic        is_mult
);

    logic [31:0] quo_reg;
    logic [16:0] rem_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic [16:0] shifted;

    assign shifted = {rem_reg[15:0], quo_reg[31]};
    assign done = busy_reg && (cnt_reg == 6'd32);
    assign is_mult = (divisor != 16'd0) && (rem_reg == 17'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg <= '0;
            quo_reg <= dividend;
            rem_reg <= '0;
        end else if (busy_reg) begin
            if (cnt_reg == 6'd32) begin
                busy_reg <= 1'b0;
            end else begin
                cnt_reg <= cnt_reg + 6'd1;
                quo_reg <= {quo_reg[30:0], 1'b0};
                if (divisor != 16'd0 && shifted >= {1'b0, divisor}) begin
                    rem_reg <= shifted - {1'b0, divisor};
                end else begin
                    rem_reg <= shifted;
                end
            end
        end
    end

endmodule

FILE: rtl/core/ptstu_back.sv
// ----------------------------------------------------------------------------
// ptstu_back: command executor
// Sequencer that walks the timer and task tables and emits result words.
// ----------------------------------------------------------------------------
module ptstu_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [15:0]       tick_ms,
    input  logic [4:0]        tasks_in_use,
    input  logic [4:0]        timers_in_use,
    input  logic              q_valid,
    output logic              q_pop,
    input  ptstu_pkg::qword_t q_word,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [39:0]       m_tdata,
    output logic              m_tlast,
    output logic [1:0]        m_tuser
);

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_TMR, S_TSK, S_DONE, S_REPLY, S_OUT
    } state_t;

    localparam int IDX_W_L = ptstu_pkg::IDX_W;

    state_t state_reg, ret_reg;
    ptstu_pkg::qword_t cur_reg;
    logic [31:0] elapsed_reg;
    logic [4:0]  tasks_reg, timers_reg;
    logic [31:0] period_reg [ptstu_pkg::NUM_SLOTS];
    logic [31:0] last_reg [ptstu_pkg::NUM_SLOTS];
    logic [31:0] tout_reg [ptstu_pkg::NUM_SLOTS];
    logic [31:0] rem_reg [ptstu_pkg::NUM_SLOTS];
    logic [ptstu_pkg::NUM_SLOTS-1:0] en_reg, run_reg;
    logic [4:0]  idx_reg;
    logic        ov_reg;
    logic [1:0]  okind_reg;
    logic [4:0]  oslot_reg;
    logic        ook_reg, olast_reg;
    logic [31:0] oval_reg;

    logic [4:0] tl, ml;
    logic [IDX_W_L-1:0] ti, mi, wi;
    logic task_ok, timer_ok;
    logic div_start, div_done, div_mult;
    logic [31:0] diff;

    assign tl = (tasks_in_use > 5'd16) ? 5'd16 : tasks_in_use;
    assign ml = (timers_in_use > 5'd16) ? 5'd16 : timers_in_use;
    assign task_ok = (cur_reg.id != 8'd0) && (cur_reg.id <= {3'd0, tl});
    assign timer_ok = (cur_reg.id != 8'd0) && (cur_reg.id <= {3'd0, ml});
    assign ti = IDX_W_L'(cur_reg.id - 8'd1);
    assign mi = ti;
    assign wi = idx_reg[3:0];
    assign diff = elapsed_reg - last_reg[wi];

    assign q_pop = (state_reg == S_IDLE) && q_valid;
    assign div_start = q_pop;

    ptstu_divchk u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(q_word.val), .divisor(tick_ms),
        .done(div_done), .is_mult(div_mult)
    );

    assign m_tvalid = ov_reg;
    assign m_tdata = {2'd0, oval_reg, ook_reg, oslot_reg};
    assign m_tlast = olast_reg;
    assign m_tuser = okind_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ret_reg <= S_IDLE;
            ov_reg <= 1'b0;
            elapsed_reg <= '0;
            tasks_reg <= '0;
            timers_reg <= '0;
            en_reg <= '0;
            run_reg <= '0;
            for (int k = 0; k < ptstu_pkg::NUM_SLOTS; k++) begin
                period_reg[k] <= '0;
                last_reg[k] <= '0;
                tout_reg[k] <= '0;
                rem_reg[k] <= '0;
            end
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        cur_reg <= q_word;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        idx_reg <= '0;
                        if (cur_reg.cmd == ptstu_pkg::CMD_TICK) begin
                            elapsed_reg <= elapsed_reg + {16'd0, tick_ms};
                            state_reg <= S_TMR;
                        end else begin
                            state_reg <= S_REPLY;
                        end
                    end
                end
                S_TMR: begin
                    if (idx_reg >= ml) begin
                        idx_reg <= '0;
                        state_reg <= S_TSK;
                    end else begin
                        idx_reg <= idx_reg + 5'd1;
                        if (run_reg[wi]) begin
                            if (rem_reg[wi] > {16'd0, tick_ms}) begin
                                rem_reg[wi] <= rem_reg[wi] - {16'd0, tick_ms};
                            end else begin
                                rem_reg[wi] <= '0;
                                run_reg[wi] <= 1'b0;
                                okind_reg <= ptstu_pkg::EV_EXPIRE;
                                oslot_reg <= idx_reg + 5'd1;
                                ook_reg <= 1'b1;
                                oval_reg <= '0;
                                olast_reg <= 1'b0;
                                ov_reg <= 1'b1;
                                ret_reg <= S_TMR;
                                state_reg <= S_OUT;
                            end
                        end
                    end
                end
                S_TSK: begin
                    if (idx_reg >= tl) begin
                        state_reg <= S_DONE;
                    end else begin
                        idx_reg <= idx_reg + 5'd1;
                        if (en_reg[wi] && diff >= period_reg[wi]) begin
                            last_reg[wi] <= elapsed_reg;
                            okind_reg <= ptstu_pkg::EV_DUE;
                            oslot_reg <= idx_reg + 5'd1;
                            ook_reg <= 1'b1;
                            oval_reg <= '0;
                            olast_reg <= 1'b0;
                            ov_reg <= 1'b1;
                            ret_reg <= S_TSK;
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_DONE: begin
                    okind_reg <= ptstu_pkg::EV_DONE;
                    oslot_reg <= '0;
                    ook_reg <= 1'b1;
                    oval_reg <= '0;
                    olast_reg <= 1'b1;
                    ov_reg <= 1'b1;
                    ret_reg <= S_IDLE;
                    state_reg <= S_OUT;
                end
                S_REPLY: begin
                    okind_reg <= ptstu_pkg::EV_REPLY;
                    oslot_reg <= '0;
                    ook_reg <= 1'b0;
                    oval_reg <= '0;
                    olast_reg <= 1'b1;
                    ov_reg <= 1'b1;
                    ret_reg <= S_IDLE;
                    state_reg <= S_OUT;
                    case (cur_reg.cmd)
                        ptstu_pkg::CMD_REG_TASK: begin
                            if (div_mult && tasks_reg < tl) begin
                                period_reg[tasks_reg[3:0]] <= cur_reg.val;
                                last_reg[tasks_reg[3:0]] <= elapsed_reg;
                                en_reg[tasks_reg[3:0]] <= 1'b1;
                                tasks_reg <= tasks_reg + 5'd1;
                                oslot_reg <= tasks_reg + 5'd1;
                                ook_reg <= 1'b1;
                            end
                        end
                        ptstu_pkg::CMD_STOP_TASK, ptstu_pkg::CMD_START_TASK: begin
                            if (task_ok) begin
                                en_reg[ti] <= (cur_reg.cmd == ptstu_pkg::CMD_START_TASK);
                                oslot_reg <= cur_reg.id[4:0];
                                ook_reg <= 1'b1;
                            end
                        end
                        ptstu_pkg::CMD_SET_PERIOD: begin
                            if (task_ok && div_mult) begin
                                period_reg[ti] <= cur_reg.val;
                                last_reg[ti] <= elapsed_reg;
                                oslot_reg <= cur_reg.id[4:0];
                                ook_reg <= 1'b1;
                            end
                        end
                        ptstu_pkg::CMD_REG_TIMER: begin
                            if (cur_reg.val > {16'd0, tick_ms} && div_mult
                                && timers_reg < ml) begin
                                tout_reg[timers_reg[3:0]] <= cur_reg.val;
                                rem_reg[timers_reg[3:0]] <= cur_reg.val;
                                run_reg[timers_reg[3:0]] <= 1'b0;
                                timers_reg <= timers_reg + 5'd1;
                                oslot_reg <= timers_reg + 5'd1;
                                ook_reg <= 1'b1;
                            end
                        end
                        ptstu_pkg::CMD_RELOAD: begin
                            if (timer_ok) begin
                                tout_reg[mi] <= cur_reg.val;
                                rem_reg[mi] <= cur_reg.val;
                                run_reg[mi] <= 1'b1;
                                oslot_reg <= cur_reg.id[4:0];
                                ook_reg <= 1'b1;
                            end
                        end
                        ptstu_pkg::CMD_START_TMR: begin
                            if (timer_ok) begin
                                rem_reg[mi] <= tout_reg[mi];
                                run_reg[mi] <= 1'b1;
                                oslot_reg <= cur_reg.id[4:0];
                                ook_reg <= 1'b1;
                            end
                        end
                        ptstu_pkg::CMD_STOP_TMR: begin
                            if (timer_ok) begin
                                run_reg[mi] <= 1'b0;
                                oslot_reg <= cur_reg.id[4:0];
                                ook_reg <= 1'b1;
                            end
                        end
                        ptstu_pkg::CMD_READ_TMR: begin
                            if (timer_ok) begin
                                oval_reg <= rem_reg[mi];
                                oslot_reg <= cur_reg.id[4:0];
                                ook_reg <= 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                S_OUT: begin
                    if (m_tready) begin
                        ov_reg <= 1'b0;
                        state_reg <= ret_reg;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/core/periodic_task_and_soft_timer_unit.sv
// ----------------------------------------------------------------------------
// periodic_task_and_soft_timer_unit: task dispatcher and software timers
// Top level joining the command queue, the executor and the config port.
// ----------------------------------------------------------------------------
// Commands enter on the s_ stream, one word per command: s_tdata carries
// the command, slot id and value. Results leave on the m_ stream; each
// command but a tick yields one reply word; a tick yields one per expired
// timer, one per due task and a closing done word marked by m_tlast.
// A four-word queue decouples acceptance from execution, so commands are
// taken while the executor is still busy, until the queue is full.
// The executor pulls a command from the queue into S_DIV and runs the
// serial divisibility check on its value (one quotient bit per cycle
// plus a finishing step); a reply then passes through S_REPLY and S_OUT.
// A tick instead walks the usable timers and then the usable tasks at one
// entry per cycle while no word waits in S_OUT, emitting each expiry or
// due word through S_OUT, and ends with the done word via S_DONE and S_OUT.
// A stalled receiver holds the executor on the current word; once the
// queue is full s_tready drops until the receiver takes words again.
// Reset (aresetn low, synchronous) clears all tables and counters and
// loads tick_ms 1 and 16 usable slots of each kind. Configuration writes
// on the cfg_ channel are always ready and should be made while idle.
// ----------------------------------------------------------------------------
module periodic_task_and_soft_timer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // command[3:0], slot_id[11:4], value_word[43:12]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // event_slot[4:0], ok_flag[5], value_out[37:6]
    output logic        m_tlast,
    output logic [1:0]  m_tuser,   // event_kind[1:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic [15:0] tick_ms_reg;
    logic [4:0]  tasks_in_use_reg, timers_in_use_reg;
    ptstu_pkg::qword_t in_word, q_word;
    logic q_valid, q_pop;

    assign cfg_ready = 1'b1;
    assign in_word.cmd = s_tdata[3:0];
    assign in_word.id = s_tdata[11:4];
    assign in_word.val = s_tdata[43:12];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_ms_reg <= 16'd1;
            tasks_in_use_reg <= 5'd16;
            timers_in_use_reg <= 5'd16;
        end else if (cfg_valid) begin
            case (cfg_index)
                ptstu_pkg::CFG_TICK_MS: tick_ms_reg <= cfg_data[15:0];
                ptstu_pkg::CFG_TASKS: tasks_in_use_reg <= cfg_data[4:0];
                ptstu_pkg::CFG_TIMERS: timers_in_use_reg <= cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    ptstu_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_word(in_word),
        .q_valid(q_valid), .q_pop(q_pop), .q_word(q_word)
    );

    ptstu_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .tick_ms(tick_ms_reg), .tasks_in_use(tasks_in_use_reg),
        .timers_in_use(timers_in_use_reg),
        .q_valid(q_valid), .q_pop(q_pop), .q_word(q_word),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser)
    );

endmodule
